// ===== sv/ttlc_pkg.sv =====
// Package for the TTL message store: widths, opcodes, status codes,
// register indexes, controller command struct and a floor subtract helper.
// No dependencies.
`default_nettype none
package ttlc_pkg;
  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned MAX_RES   = 32;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned HOP_W     = 8;
  localparam int unsigned BYTES_W   = 24;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ENTRY_W   = KEY_W + SIZE_W + TIME_W + HOP_W;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_AGE    = 3'd3;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_PRESENT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 1'd1;

  localparam logic [BYTES_W-1:0] BUDGET_RST = 24'd5000000;

  typedef struct packed {
    logic load;
    logic rd;
    logic chk;
    logic fin;
  } ctrl_cmd_t;

  function automatic logic [BYTES_W-1:0] floor_sub(input logic [BYTES_W-1:0] a,
                                                   input logic [SIZE_W-1:0] b);
    logic [BYTES_W-1:0] bx;
    bx = BYTES_W'(b);
    floor_sub = (a >= bx) ? a - bx : '0;
  endfunction
endpackage
`default_nettype wire

// ===== sv/ttlc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ttlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/ttlc_ctrl.sv =====
// Controller: sequences load, slot scan and commit for each request.
// Depends on ttlc_pkg.
`default_nettype none
module ttlc_ctrl #(
  parameter int unsigned DEPTH = ttlc_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ttlc_pkg::OP_W-1:0]     opcode,
  output logic                               busy,
  output ttlc_pkg::ctrl_cmd_t                cmd,
  output logic [$clog2(DEPTH)-1:0]           rd_addr,
  output logic [$clog2(DEPTH)-1:0]           chk_idx
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic          go;

  assign busy = (state_r != S_IDLE);
  assign go   = start && !busy && (opcode <= ttlc_pkg::OP_SELECT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (go) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(DEPTH)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cmd.load = go;
  assign cmd.rd   = (state_r == S_SCAN) && (cnt_r < CW'(DEPTH));
  assign cmd.chk  = (state_r == S_SCAN) && (cnt_r != '0);
  assign cmd.fin  = (state_r == S_FIN);
  assign rd_addr  = cnt_r[AW-1:0];
  assign chk_idx  = AW'(cnt_r - 1'b1);
endmodule
`default_nettype wire

// ===== sv/ttlc_dp.sv =====
// Datapath: slot RAM, valid bits, byte total, configuration registers,
// scan trackers and result registers. Depends on ttlc_pkg and ttlc_ram.
`default_nettype none
module ttlc_dp #(
  parameter int unsigned DEPTH = ttlc_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  ttlc_pkg::ctrl_cmd_t                     cmd,
  input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
  input  wire logic [$clog2(DEPTH)-1:0]           chk_idx,
  input  wire logic                               cfg_we,
  input  wire logic [ttlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ttlc_pkg::BYTES_W-1:0]       cfg_data,
  input  wire logic [ttlc_pkg::OP_W-1:0]          in_opcode,
  input  wire logic [ttlc_pkg::KEY_W-1:0]         in_key,
  input  wire logic [ttlc_pkg::SIZE_W-1:0]        in_payload_size,
  input  wire logic [ttlc_pkg::HOP_W-1:0]         in_hop_count,
  input  wire logic [ttlc_pkg::HOP_W-1:0]         in_hop_limit,
  input  wire logic [ttlc_pkg::TIME_W-1:0]        in_now,
  output logic                                    out_valid,
  output logic [ttlc_pkg::ST_W-1:0]               out_status,
  output logic [ttlc_pkg::KEY_W-1:0]              out_entry_key,
  output logic [ttlc_pkg::SLOT_W-1:0]             out_slot,
  output logic [ttlc_pkg::SIZE_W-1:0]             out_entry_size,
  output logic [ttlc_pkg::HOP_W-1:0]              out_entry_hops,
  output logic [ttlc_pkg::TIME_W-1:0]             out_entry_expiry,
  output logic                                    out_evicted,
  output logic [ttlc_pkg::KEY_W-1:0]              out_evicted_key,
  output logic [ttlc_pkg::BYTES_W-1:0]            out_bytes_held,
  output logic                                    out_last
);
  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned KW  = ttlc_pkg::KEY_W;
  localparam int unsigned SW  = ttlc_pkg::SIZE_W;
  localparam int unsigned TW  = ttlc_pkg::TIME_W;
  localparam int unsigned HW  = ttlc_pkg::HOP_W;
  localparam int unsigned BW  = ttlc_pkg::BYTES_W;
  localparam int unsigned NW  = $clog2(ttlc_pkg::MAX_RES + 1);

  logic [BW-1:0]                 budget_r;
  logic [ttlc_pkg::AGE_W-1:0]    max_age_r;
  logic [DEPTH-1:0]              valid_r;
  logic [BW-1:0]                 held_r;

  logic [ttlc_pkg::OP_W-1:0]     op_r;
  logic [KW-1:0]                 key_r;
  logic [SW-1:0]                 psize_r;
  logic [HW-1:0]                 hops_r;
  logic [HW-1:0]                 limit_r;
  logic [TW-1:0]                 now_r;

  logic                          found_r;
  logic [AW-1:0]                 fidx_r;
  logic [KW-1:0]                 fkey_r;
  logic [SW-1:0]                 fsize_r;
  logic [TW-1:0]                 fexp_r;
  logic [HW-1:0]                 fhops_r;
  logic                          mv_r;
  logic [AW-1:0]                 mi_r;
  logic [KW-1:0]                 mkey_r;
  logic [SW-1:0]                 msize_r;
  logic [TW-1:0]                 mexp_r;
  logic                          ff_r;
  logic [AW-1:0]                 fi_r;
  logic                          pend_r;
  logic [NW-1:0]                 sel_cnt_r;
  logic [KW-1:0]                 sel_key_r;
  logic [ttlc_pkg::SLOT_W-1:0]   sel_slot_r;
  logic [SW-1:0]                 sel_size_r;
  logic [HW-1:0]                 sel_hops_r;
  logic [TW-1:0]                 sel_exp_r;

  logic                          out_valid_r;
  logic [ttlc_pkg::ST_W-1:0]     out_status_r;
  logic [KW-1:0]                 out_key_r;
  logic [ttlc_pkg::SLOT_W-1:0]   out_slot_r;
  logic [SW-1:0]                 out_size_r;
  logic [HW-1:0]                 out_hops_r;
  logic [TW-1:0]                 out_exp_r;
  logic                          out_ev_r;
  logic [KW-1:0]                 out_evk_r;
  logic [BW-1:0]                 out_held_r;
  logic                          out_last_r;

  logic [ttlc_pkg::ENTRY_W-1:0]  rdata;
  logic [ttlc_pkg::ENTRY_W-1:0]  wdata;
  logic [KW-1:0]                 rkey;
  logic [SW-1:0]                 rsize;
  logic [TW-1:0]                 rexp;
  logic [HW-1:0]                 rhops;
  logic                          rvalid;
  logic                          hit;
  logic                          sel_hit;
  logic                          ev;
  logic [BW-1:0]                 held_ev;
  logic                          use_mi;
  logic                          has_free;
  logic [AW-1:0]                 fslot;
  logic [TW:0]                   exp_sum;
  logic [TW-1:0]                 exp_new;
  logic                          we;

  assign {rkey, rsize, rexp, rhops} = rdata;
  assign rvalid  = valid_r[chk_idx];
  assign hit     = rvalid && (rkey == key_r);
  assign sel_hit = rvalid && (op_r == ttlc_pkg::OP_SELECT)
                   && ((HW+1)'(rhops) + 1'b1 < (HW+1)'(limit_r))
                   && (sel_cnt_r < NW'(ttlc_pkg::MAX_RES));

  assign ev       = !found_r && mv_r && (budget_r != '0)
                    && ((BW+1)'(held_r) + (BW+1)'(psize_r) > (BW+1)'(budget_r));
  assign held_ev  = ev ? ttlc_pkg::floor_sub(held_r, msize_r) : held_r;
  assign use_mi   = ev && (!ff_r || (mi_r < fi_r));
  assign has_free = use_mi || ff_r;
  assign fslot    = use_mi ? mi_r : fi_r;
  assign exp_sum  = (TW+1)'(now_r) + (TW+1)'(max_age_r);
  assign exp_new  = exp_sum[TW] ? '1 : exp_sum[TW-1:0];
  assign we       = cmd.fin && (op_r == ttlc_pkg::OP_INSERT) && !found_r && has_free;
  assign wdata    = {key_r, psize_r, exp_new, hops_r};

  ttlc_ram #(
    .WIDTH (ttlc_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (fslot),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r  <= ttlc_pkg::BUDGET_RST;
      max_age_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ttlc_pkg::REG_BYTE_BUDGET: budget_r  <= cfg_data;
        ttlc_pkg::REG_MAX_AGE:     max_age_r <= cfg_data[ttlc_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      key_r   <= in_key;
      psize_r <= in_payload_size;
      hops_r  <= in_hop_count;
      limit_r <= in_hop_limit;
      now_r   <= in_now;
    end
    if (cmd.chk) begin
      if (hit && !found_r) begin
        fidx_r  <= chk_idx;
        fkey_r  <= rkey;
        fsize_r <= rsize;
        fexp_r  <= rexp;
        fhops_r <= rhops;
      end
      if (rvalid && (!mv_r || (rexp < mexp_r))) begin
        mi_r    <= chk_idx;
        mkey_r  <= rkey;
        msize_r <= rsize;
        mexp_r  <= rexp;
      end
      if (!rvalid && !ff_r) begin
        fi_r <= chk_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      held_r    <= '0;
      found_r   <= 1'b0;
      mv_r      <= 1'b0;
      ff_r      <= 1'b0;
      pend_r    <= 1'b0;
      sel_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        found_r   <= 1'b0;
        mv_r      <= 1'b0;
        ff_r      <= 1'b0;
        pend_r    <= 1'b0;
        sel_cnt_r <= '0;
      end
      if (cmd.chk) begin
        if (hit) found_r <= 1'b1;
        if (rvalid) mv_r <= 1'b1;
        if (!rvalid) ff_r <= 1'b1;
        if (sel_hit) begin
          pend_r    <= 1'b1;
          sel_cnt_r <= sel_cnt_r + 1'b1;
        end
        if ((op_r == ttlc_pkg::OP_AGE) && rvalid && (rexp < now_r)) begin
          valid_r[chk_idx] <= 1'b0;
          held_r           <= ttlc_pkg::floor_sub(held_r, rsize);
        end
      end
      if (cmd.fin) begin
        case (op_r)
          ttlc_pkg::OP_INSERT: begin
            if (!found_r) begin
              if (ev) valid_r[mi_r] <= 1'b0;
              if (has_free) begin
                valid_r[fslot] <= 1'b1;
                held_r         <= held_ev + BW'(psize_r);
              end else begin
                held_r <= held_ev;
              end
            end
          end
          ttlc_pkg::OP_DELETE: begin
            if (found_r) begin
              valid_r[fidx_r] <= 1'b0;
              held_r          <= ttlc_pkg::floor_sub(held_r, fsize_r);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result registers; hold each select match until the next one shows it is not the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.chk && sel_hit && pend_r) || cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk && sel_hit) begin
      sel_key_r  <= rkey;
      sel_slot_r <= ttlc_pkg::SLOT_W'(chk_idx);
      sel_size_r <= rsize;
      sel_hops_r <= rhops;
      sel_exp_r  <= rexp;
      if (pend_r) begin
        out_last_r   <= 1'b0;
        out_status_r <= ttlc_pkg::ST_DONE;
        out_key_r    <= sel_key_r;
        out_slot_r   <= sel_slot_r;
        out_size_r   <= sel_size_r;
        out_hops_r   <= sel_hops_r;
        out_exp_r    <= sel_exp_r;
        out_ev_r     <= 1'b0;
        out_evk_r    <= '0;
        out_held_r   <= held_r;
      end
    end else if (cmd.fin) begin
      out_last_r   <= 1'b1;
      out_status_r <= ttlc_pkg::ST_DONE;
      out_key_r    <= '0;
      out_slot_r   <= '0;
      out_size_r   <= '0;
      out_hops_r   <= '0;
      out_exp_r    <= '0;
      out_ev_r     <= 1'b0;
      out_evk_r    <= '0;
      out_held_r   <= held_r;
      case (op_r)
        ttlc_pkg::OP_INSERT: begin
          if (found_r) begin
            out_status_r <= ttlc_pkg::ST_PRESENT;
            out_key_r    <= fkey_r;
            out_slot_r   <= ttlc_pkg::SLOT_W'(fidx_r);
            out_size_r   <= fsize_r;
            out_hops_r   <= fhops_r;
            out_exp_r    <= fexp_r;
          end else begin
            out_ev_r  <= ev;
            out_evk_r <= ev ? mkey_r : '0;
            if (has_free) begin
              out_key_r  <= key_r;
              out_slot_r <= ttlc_pkg::SLOT_W'(fslot);
              out_size_r <= psize_r;
              out_hops_r <= hops_r;
              out_exp_r  <= exp_new;
              out_held_r <= held_ev + BW'(psize_r);
            end else begin
              out_status_r <= ttlc_pkg::ST_FULL;
              out_held_r   <= held_ev;
            end
          end
        end
        ttlc_pkg::OP_LOOKUP, ttlc_pkg::OP_DELETE: begin
          if (found_r) begin
            out_key_r  <= fkey_r;
            out_slot_r <= ttlc_pkg::SLOT_W'(fidx_r);
            out_size_r <= fsize_r;
            out_hops_r <= fhops_r;
            out_exp_r  <= fexp_r;
            if (op_r == ttlc_pkg::OP_DELETE) begin
              out_held_r <= ttlc_pkg::floor_sub(held_r, fsize_r);
            end
          end else begin
            out_status_r <= ttlc_pkg::ST_MISSING;
          end
        end
        ttlc_pkg::OP_SELECT: begin
          if (pend_r) begin
            out_key_r  <= sel_key_r;
            out_slot_r <= sel_slot_r;
            out_size_r <= sel_size_r;
            out_hops_r <= sel_hops_r;
            out_exp_r  <= sel_exp_r;
          end else begin
            out_status_r <= ttlc_pkg::ST_MISSING;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_key    = out_key_r;
  assign out_slot         = out_slot_r;
  assign out_entry_size   = out_size_r;
  assign out_entry_hops   = out_hops_r;
  assign out_entry_expiry = out_exp_r;
  assign out_evicted      = out_ev_r;
  assign out_evicted_key  = out_evk_r;
  assign out_bytes_held   = out_held_r;
  assign out_last         = out_last_r;
endmodule
`default_nettype wire

// ===== sv/ttl_cache_with_byte_budget_core.sv =====
// TTL message store with a payload byte budget. Each request runs a one-slot-per-cycle
// scan of the slot RAM and then a commit; a new request may start once busy drops.
// Select results stream during the scan and the commit, one cycle each; the receiver
// cannot stall. Synchronous active-low reset clears valid bits, byte total, scan flags
// and control state; the byte budget takes its reset value and the maximum age is zero.
// Depends on ttlc_pkg, ttlc_ctrl, ttlc_dp and ttlc_ram.
`default_nettype none
module ttl_cache_with_byte_budget_core #(
  parameter int unsigned DEPTH = ttlc_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ttlc_pkg::OP_W-1:0]         in_opcode,
  input  wire logic [ttlc_pkg::KEY_W-1:0]        in_key,
  input  wire logic [ttlc_pkg::SIZE_W-1:0]       in_payload_size,
  input  wire logic [ttlc_pkg::HOP_W-1:0]        in_hop_count,
  input  wire logic [ttlc_pkg::HOP_W-1:0]        in_hop_limit,
  input  wire logic [ttlc_pkg::TIME_W-1:0]       in_now,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ttlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ttlc_pkg::BYTES_W-1:0]      cfg_data,
  output logic                                   out_valid,
  output logic [ttlc_pkg::ST_W-1:0]              out_status,
  output logic [ttlc_pkg::KEY_W-1:0]             out_entry_key,
  output logic [ttlc_pkg::SLOT_W-1:0]            out_slot,
  output logic [ttlc_pkg::SIZE_W-1:0]            out_entry_size,
  output logic [ttlc_pkg::HOP_W-1:0]             out_entry_hops,
  output logic [ttlc_pkg::TIME_W-1:0]            out_entry_expiry,
  output logic                                   out_evicted,
  output logic [ttlc_pkg::KEY_W-1:0]             out_evicted_key,
  output logic [ttlc_pkg::BYTES_W-1:0]           out_bytes_held,
  output logic                                   out_last
);
  localparam int unsigned AW = $clog2(DEPTH);

  ttlc_pkg::ctrl_cmd_t cmd;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       chk_idx;

  assign cfg_ready = 1'b1;

  ttlc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .opcode  (in_opcode),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .chk_idx (chk_idx)
  );

  ttlc_dp #(.DEPTH(DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .chk_idx          (chk_idx),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_opcode),
    .in_key           (in_key),
    .in_payload_size  (in_payload_size),
    .in_hop_count     (in_hop_count),
    .in_hop_limit     (in_hop_limit),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_key    (out_entry_key),
    .out_slot         (out_slot),
    .out_entry_size   (out_entry_size),
    .out_entry_hops   (out_entry_hops),
    .out_entry_expiry (out_entry_expiry),
    .out_evicted      (out_evicted),
    .out_evicted_key  (out_evicted_key),
    .out_bytes_held   (out_bytes_held),
    .out_last         (out_last)
  );

  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after final result of a request");

  a_full_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ttlc_pkg::ST_FULL) |-> (out_entry_key == '0)
      && (out_slot == '0) && (out_entry_expiry == '0))
    else $error("table-full result carries an entry");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_opcode <= ttlc_pkg::OP_SELECT) |=> busy)
    else $error("accepted request did not raise busy");
endmodule
`default_nettype wire
